// ===== rtl/mtenc_pkg.sv =====
// Package for the multi-turn encoder tracker.
// Holds the geometry constants, frame kind codes and register indexes.
// No dependencies.
package mtenc_pkg;

  localparam int COUNTS_PER_TURN = 8192;
  localparam int TURN_BITS       = 16;
  localparam int WARMUP_LIMIT    = 10;
  localparam int SKIP_FRAMES     = 5;

  localparam int ANGLE_W   = 40;
  localparam int TOTAL_W   = 32;
  localparam int WORD_W    = 16;
  localparam int ID_W      = 11;
  localparam int OFFSET_W  = 13;
  localparam int WARMUP_W  = 4;

  // Q10 degrees per count is 45/1024; Q12 degrees at the gearbox output is 5/4096
  localparam int MOTOR_SCALE  = 45;
  localparam int OUTPUT_SCALE = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_ID      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_OFFSET  = 2'd2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_OTHER    = 2'd0;
  localparam kind_t KIND_YAW      = 2'd1;
  localparam kind_t KIND_WARMUP   = 2'd2;
  localparam kind_t KIND_FRICTION = 2'd3;

  localparam int OUT_DATA_W = 232;

endpackage

// ===== rtl/multiturn_encoder_tracker.sv =====
// Multi-turn encoder tracker: top level.
// Unwraps yaw rotor position from feedback frames and reports angles.
// Depends on mtenc_pkg.
//
// Usage:
//   Input stream (in_*): one received frame per transaction; in_tuser holds the
//   11-bit identifier, in_tdata the four data bytes.
//   Output stream (out_*): exactly one result per input frame, in order;
//   out_tuser holds the frame kind.
//   Configuration (cfg_*): write yaw id, friction id and position offset while
//   the block is idle; a write takes effect at the clock edge it is seen.
// Pipeline: a frame is registered in the middle stage and then in the result
// stage before its result is offered on out_*.
// Throughput: one frame per cycle while out_tready is high. The turn counter,
// previous position and warm-up count update in the accept cycle; the angle
// scaling and the warm-up offset capture run one stage later, in frame order.
// Reset (rst_n low, synchronous): all tracking state, configuration registers
// and both pipeline stage valid flags clear; no result is pending afterwards.
// Stall: when out_tready is low the result holds, the middle stage holds
// one more frame, and in_tready drops once both are full.
module multiturn_encoder_tracker
  import mtenc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // byte_zero [7:0], byte_one [15:8], byte_two [23:16], byte_three [31:24]
  input  logic [31:0]           in_tdata,
  // frame_id [10:0]
  input  logic [ID_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // rotor_position [15:0], position_rate [31:16], turn_count [47:32],
  // total_count [79:48], motor_angle_q10 [119:80], output_angle_q12 [159:120],
  // motor_speed [175:160], angle_offset_q10 [215:176], friction_speed [231:216]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // frame_kind [1:0]
  output logic [1:0]            out_tuser
);

  // configuration
  logic [ID_W-1:0]     yaw_id_r;
  logic [ID_W-1:0]     fric_id_r;
  logic [OFFSET_W-1:0] pos_offset_r;

  // tracking state
  logic [WORD_W-1:0]          prev_pos_r, prev_pos_nxt;
  logic signed [TURN_BITS-1:0] turns_r, turns_nxt;
  logic [WARMUP_W-1:0]        warm_r, warm_nxt;
  logic [WORD_W-1:0]          fric_speed_r, fric_speed_nxt;
  logic signed [ANGLE_W-1:0]  last_angle_r, last_angle_nxt;
  logic signed [ANGLE_W-1:0]  captured_r, captured_nxt;

  // middle stage
  logic                       a_valid_r;
  kind_t                      a_kind_r, a_kind_nxt;
  logic                       a_capture_r, a_capture_nxt;
  logic [WORD_W-1:0]          a_rate_r, a_rate_nxt;
  logic signed [TOTAL_W-1:0]  a_total_r, a_total_nxt;
  logic [WORD_W-1:0]          a_yspeed_r, a_yspeed_nxt;
  logic [WORD_W-1:0]          a_prev_r;
  logic [WORD_W-1:0]          a_turns_r;
  logic [WORD_W-1:0]          a_fric_r;

  // result stage
  logic                       out_valid_r;
  kind_t                      out_kind_r;
  logic [WORD_W-1:0]          out_pos_r, out_rate_r, out_turns_r, out_yspeed_r, out_fric_r;
  logic signed [TOTAL_W-1:0]  out_total_r;
  logic signed [ANGLE_W-1:0]  out_angle_r, out_oangle_r, out_offset_r;

  logic in_fire, a_adv, out_load_ok;

  assign out_load_ok = !out_valid_r || out_tready;
  assign a_adv       = a_valid_r && out_load_ok;
  assign in_tready   = !a_valid_r || a_adv;
  assign in_fire     = in_tvalid && in_tready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_id_r     <= '0;
      fric_id_r    <= '0;
      pos_offset_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_YAW_ID:      yaw_id_r     <= cfg_wdata[ID_W-1:0];
        CFG_FRICTION_ID: fric_id_r    <= cfg_wdata[ID_W-1:0];
        CFG_POS_OFFSET:  pos_offset_r <= cfg_wdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- unwrap (first stage) ----------------
  localparam logic signed [WORD_W:0] HALF_TURN = (WORD_W+1)'(COUNTS_PER_TURN / 2);
  localparam logic signed [WORD_W:0] FULL_TURN = (WORD_W+1)'(COUNTS_PER_TURN);
  localparam logic signed [TOTAL_W-1:0] TURN_SCALE = TOTAL_W'(COUNTS_PER_TURN);

  logic [WORD_W-1:0]         pos_word, speed_word;
  logic signed [WORD_W:0]    diff, rate_full;
  logic signed [TOTAL_W-1:0] turns_ext;
  logic                      is_yaw, is_fric, processed;

  assign pos_word   = {in_tdata[7:0], in_tdata[15:8]};
  assign speed_word = {in_tdata[23:16], in_tdata[31:24]};
  assign is_yaw     = (in_tuser == yaw_id_r);
  assign is_fric    = (in_tuser == fric_id_r);
  assign diff       = $signed({1'b0, pos_word}) - $signed({1'b0, prev_pos_r});
  assign turns_ext  = TOTAL_W'(turns_nxt);

  always_comb begin
    warm_nxt       = warm_r;
    turns_nxt      = turns_r;
    prev_pos_nxt   = prev_pos_r;
    fric_speed_nxt = fric_speed_r;
    a_capture_nxt  = 1'b0;
    a_kind_nxt     = KIND_OTHER;
    a_rate_nxt     = '0;
    a_total_nxt    = '0;
    a_yspeed_nxt   = '0;
    rate_full      = diff;
    processed      = 1'b0;
    if (is_yaw) begin
      a_kind_nxt = KIND_WARMUP;
      if (warm_r < WARMUP_W'(WARMUP_LIMIT)) begin
        warm_nxt      = warm_r + 1'b1;
        a_capture_nxt = 1'b1;
      end
      processed = (warm_nxt > WARMUP_W'(SKIP_FRAMES));
      if (processed) begin
        priority if (diff > HALF_TURN) begin
          turns_nxt = turns_r - 1'b1;
          rate_full = diff - FULL_TURN;
        end else if (diff < -HALF_TURN) begin
          turns_nxt = turns_r + 1'b1;
          rate_full = diff + FULL_TURN;
        end else begin
          rate_full = diff;
        end
        prev_pos_nxt = pos_word;
        a_rate_nxt   = rate_full[WORD_W-1:0];
        a_total_nxt  = turns_ext * TURN_SCALE + TOTAL_W'(pos_word) - TOTAL_W'(pos_offset_r);
        a_yspeed_nxt = speed_word;
        a_kind_nxt   = KIND_YAW;
      end
    end else if (is_fric) begin
      fric_speed_nxt = speed_word;
      a_kind_nxt     = KIND_FRICTION;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r    <= 1'b0;
      warm_r       <= '0;
      turns_r      <= '0;
      prev_pos_r   <= '0;
      fric_speed_r <= '0;
    end else begin
      if (in_fire) begin
        a_valid_r    <= 1'b1;
        warm_r       <= warm_nxt;
        turns_r      <= turns_nxt;
        prev_pos_r   <= prev_pos_nxt;
        fric_speed_r <= fric_speed_nxt;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_kind_r    <= a_kind_nxt;
      a_capture_r <= a_capture_nxt;
      a_rate_r    <= a_rate_nxt;
      a_total_r   <= a_total_nxt;
      a_yspeed_r  <= a_yspeed_nxt;
      a_prev_r    <= prev_pos_nxt;
      a_turns_r   <= WORD_W'(turns_nxt);
      a_fric_r    <= fric_speed_nxt;
    end
  end

  // ---------------- angle scaling (second stage) ----------------
  logic signed [ANGLE_W-1:0] total_ext, motor_angle, output_angle;

  assign total_ext    = ANGLE_W'(a_total_r);
  assign motor_angle  = total_ext * ANGLE_W'(MOTOR_SCALE);
  assign output_angle = (a_kind_r == KIND_YAW) ? total_ext * ANGLE_W'(OUTPUT_SCALE) : '0;

  always_comb begin
    last_angle_nxt = last_angle_r;
    captured_nxt   = captured_r;
    // capture uses the angle as it stood before this frame
    if (a_capture_r) captured_nxt = last_angle_r;
    if (a_kind_r == KIND_YAW) last_angle_nxt = motor_angle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      last_angle_r <= '0;
      captured_r   <= '0;
    end else begin
      if (a_adv) begin
        out_valid_r  <= 1'b1;
        last_angle_r <= last_angle_nxt;
        captured_r   <= captured_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_kind_r   <= a_kind_r;
      out_pos_r    <= a_prev_r;
      out_rate_r   <= a_rate_r;
      out_turns_r  <= a_turns_r;
      out_total_r  <= a_total_r;
      out_angle_r  <= last_angle_nxt;
      out_oangle_r <= output_angle;
      out_yspeed_r <= a_yspeed_r;
      out_offset_r <= captured_nxt;
      out_fric_r   <= a_fric_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_fric_r, out_offset_r, out_yspeed_r, out_oangle_r, out_angle_r,
                       out_total_r, out_turns_r, out_rate_r, out_pos_r};

endmodule
